// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg: shared constants and types for the lru key-value cache
// sizes of the entry store, field widths, operation codes and stream widths
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;

	// entry index and rank width, never zero
	localparam int IDX_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	// occupancy and capacity width, able to hold MAX_ENTRIES itself
	localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
	localparam int CFG_BITS = 5;
	localparam logic [CFG_BITS-1:0] CAPACITY_RESET = CFG_BITS'(16);

	// stream payload widths, padded to whole bytes
	localparam int S_DATA_BITS = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

	typedef enum logic {
		KIND_GET = 1'b0,
		KIND_PUT = 1'b1
	} kind_t;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;

	// result flags carried in m_tuser, highest bit first
	typedef struct packed {
		logic evicted;
		logic hit;
	} result_flags_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store with lru replacement
// get and put requests on a stream, one result transfer per request
// ----------------------------------------------------------------------------
// usage
//   s_* carries requests: s_tuser is the kind (0 get, 1 put), s_tdata holds
//   lookup_key in the low bits and store_value above it (upper pad ignored)
//   m_* carries one result per request: m_tdata holds read_value, m_tuser
//   holds hit (bit 0) and evicted (bit 1)
//   cfg_we/cfg_wdata write the capacity register; write only while idle
// timing
//   a request transfer lands in the input register, the lookup, recency
//   update and replacement are done by one pass of logic from that register,
//   and the result is in the output register at the next edge, so the result
//   is offered one clock edge after its request transfer
//   throughput is one request per cycle: state updates at the same edge as
//   the result register, so the next request sees it at once
// reset
//   all entries invalid, occupancy zero, capacity 16, both stages empty
// stalls
//   while m_tready is low and a result waits, the input register holds its
//   request and s_tready drops once that register is also full
// ----------------------------------------------------------------------------
module lru_key_value_cache (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lkvc_pkg::CFG_BITS-1:0]    cfg_wdata,    // capacity
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lkvc_pkg::S_DATA_BITS-1:0] s_tdata,      // lookup_key, store_value
	input  logic                             s_tuser,      // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lkvc_pkg::M_DATA_BITS-1:0] m_tdata,      // read_value
	output logic [1:0]                       m_tuser       // hit, evicted
);

	localparam int N  = lkvc_pkg::MAX_ENTRIES;
	localparam int KB = lkvc_pkg::KEY_BITS;
	localparam int VB = lkvc_pkg::VALUE_BITS;
	localparam int IB = lkvc_pkg::IDX_BITS;
	localparam int CB = lkvc_pkg::CNT_BITS;

	// configuration
	logic [lkvc_pkg::CFG_BITS-1:0] capacity_q;

	// entry state
	logic [N-1:0]        valid_q;
	lkvc_pkg::key_t      key_q   [N];
	lkvc_pkg::value_t    value_q [N];
	lkvc_pkg::idx_t      rank_q  [N];
	lkvc_pkg::cnt_t      occ_q;

	// input register
	logic                s1_valid;
	lkvc_pkg::kind_t     kind_s1;
	lkvc_pkg::key_t      key_s1;
	lkvc_pkg::value_t    val_s1;

	// output register
	logic                    m_valid_q;
	lkvc_pkg::value_t        rd_q;
	lkvc_pkg::result_flags_t flags_q;

	// handshake
	logic advance;
	logic fire;

	assign advance  = !m_valid_q || m_tready;
	assign fire     = s1_valid && advance;
	assign s_tready = !s1_valid || advance;

	// lookup logic
	logic [N-1:0]     match;
	logic             found;
	lkvc_pkg::idx_t   where_idx;
	lkvc_pkg::idx_t   hit_rank;
	lkvc_pkg::value_t hit_value;
	lkvc_pkg::cnt_t   eff_cap;
	lkvc_pkg::cnt_t   occ_m1;
	logic             full;
	logic [N-1:0]     oldest;
	logic             evict;
	logic [N-1:0]     valid_kept;
	lkvc_pkg::idx_t   slot;
	logic             is_put;

	assign is_put = (kind_s1 == lkvc_pkg::KIND_PUT);

	// parallel key compare across all entries
	always_comb begin
		for (int i = 0; i < N; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_s1);
		end
	end

	assign found = |match;

	// lowest matching index
	always_comb begin
		where_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (match[i]) begin
				where_idx = IB'(i);
			end
		end
	end

	assign hit_rank  = rank_q[where_idx];
	assign hit_value = value_q[where_idx];

	// capacity 0 acts as 1, anything above the store size as the store size
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CB'(1);
		end else if (32'(capacity_q) > N) begin
			eff_cap = CB'(N);
		end else begin
			eff_cap = CB'(capacity_q);
		end
	end

	assign full   = (occ_q != '0) && (occ_q >= eff_cap);
	assign occ_m1 = occ_q - CB'(1);

	// ranks of valid entries run 0 .. occupancy-1, so the oldest has the top one
	always_comb begin
		for (int i = 0; i < N; i++) begin
			oldest[i] = valid_q[i] && (CB'(rank_q[i]) == occ_m1);
		end
	end

	assign evict      = is_put && !found && full;
	assign valid_kept = evict ? (valid_q & ~oldest) : valid_q;

	// lowest free slot after any eviction
	always_comb begin
		slot = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_kept[i]) begin
				slot = IB'(i);
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= lkvc_pkg::kind_t'(s_tuser);
			key_s1  <= s_tdata[KB-1:0];
			val_s1  <= s_tdata[KB+VB-1:KB];
		end
	end

	// control state: valid bits, ranks, occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= '0;
			end
		end else if (fire) begin
			if (found) begin
				// touch: entries more recent than the hit age by one
				for (int i = 0; i < N; i++) begin
					if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + IB'(1);
					end
				end
				rank_q[where_idx] <= '0;
			end else if (is_put) begin
				// insertion: every kept entry ages, new one is most recent
				for (int i = 0; i < N; i++) begin
					if (valid_kept[i]) begin
						rank_q[i] <= rank_q[i] + IB'(1);
					end
				end
				rank_q[slot] <= '0;
				valid_q      <= valid_kept | (N'(1) << slot);
				if (!evict) begin
					occ_q <= occ_q + CB'(1);
				end
			end
		end
	end

	// key and value payload
	always_ff @(posedge clk) begin
		if (fire && is_put) begin
			if (found) begin
				value_q[where_idx] <= val_s1;
			end else begin
				key_q[slot]   <= key_s1;
				value_q[slot] <= val_s1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			flags_q.hit     <= found;
			flags_q.evicted <= evict;
			if (is_put) begin
				rd_q <= '0;
			end else if (found) begin
				rd_q <= hit_value;
			end else begin
				rd_q <= '1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = lkvc_pkg::M_DATA_BITS'(rd_q);
	assign m_tuser  = {flags_q.evicted, flags_q.hit};

	// assertions

	// occupancy tracks the number of valid entries
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(valid_q)) == 32'(occ_q))
		else $error("occupancy differs from valid entry count");

	// occupancy never exceeds the store
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= N)
		else $error("occupancy above store size");

	// keys of valid entries are unique
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> $onehot0(match))
		else $error("key present in more than one entry");

	// an eviction only happens on a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(flags_q.hit && flags_q.evicted))
		else $error("eviction reported on a hit");

	// a full store that misses on a put must find an oldest entry
	a_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && evict) |-> $onehot(oldest))
		else $error("no unique least recent entry");

endmodule
